// File: rtl/krt_pkg.sv
`default_nettype none
package krt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  typedef logic [30:0] key_t;

  typedef struct packed {
    key_t        key;
    logic [63:0] title;
    logic [63:0] author;
    logic [31:0] price;
  } rec_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_LIST   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INS_WR,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SORT_LD,
    S_SORT_HOLD,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_PUT,
    S_LIST_RD,
    S_LIST_CMP,
    S_LIST_END,
    S_EMIT
  } state_e;

endpackage
`default_nettype wire

// File: rtl/krt_mem.sv
`default_nettype none
module krt_mem (
  input  wire                    clk_i,
  input  wire                    we_i,
  input  wire [krt_pkg::IDX_W-1:0] waddr_i,
  input  krt_pkg::rec_t          wdata_i,
  input  wire [krt_pkg::IDX_W-1:0] raddr_i,
  output krt_pkg::rec_t          rdata_o
);
  import krt_pkg::*;

  rec_t mem_q [ENTRIES];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/krt_cmp.sv
`default_nettype none
module krt_cmp (
  input  krt_pkg::key_t a_i,
  input  krt_pkg::key_t b_i,
  output krt_pkg::cmp_t res_o
);
  import krt_pkg::*;

  // shared key comparator: equality and a greater than b
  always_comb begin
    res_o.eq = (a_i == b_i);
    res_o.gt = (a_i > b_i);
  end

endmodule
`default_nettype wire

// File: rtl/keyed_record_table_unit.sv
// lookup, update and insert walk the table slots one by one; remove also shifts each
// later slot down by one; list first sorts the table in place, then walks it
// throughput: one command at a time, set by the record memory's single write port and the
// one shared key comparator; results leave through a registered output stage
// reset: rst_ni is asynchronous, active low; it empties the table (entry count zero)
// and clears the sequencer and output valid; record contents are not cleared
`default_nettype none
module keyed_record_table_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [2:0]                   cmd_i,
  input  wire  [30:0]                  key_i,
  input  wire  [63:0]                  title_tag_i,
  input  wire  [63:0]                  author_tag_i,
  input  wire  [31:0]                  price_cents_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [2:0]                   status_o,
  output logic [30:0]                  found_key_o,
  output logic [63:0]                  found_title_o,
  output logic [63:0]                  found_author_o,
  output logic [31:0]                  found_price_o,
  output logic [krt_pkg::IDX_W-1:0]    position_o,
  output logic [krt_pkg::CNT_W-1:0]    entry_total_o,
  output logic                         last_o
);
  import krt_pkg::*;

  // sequencer state
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;     // walking slot (search, shift, inner sort, list)
  logic [IDX_W-1:0]   i_q, i_d;         // outer sort slot
  logic [CNT_W-1:0]   used_q, used_d;
  cmd_e               cmd_q, cmd_d;
  rec_t               nrec_q, nrec_d;   // record carried in with the command
  rec_t               hold_q, hold_d;   // current minimum during an exchange pass
  rec_t               pend_q, pend_d;   // list entry waiting for its successor
  logic [IDX_W-1:0]   pend_pos_q, pend_pos_d;
  logic               pend_v_q, pend_v_d;
  rec_t               res_q, res_d;     // single result waiting to leave
  logic [IDX_W-1:0]   res_pos_q, res_pos_d;
  status_e            res_st_q, res_st_d;

  // output stage
  logic               out_valid_q, out_valid_d;
  rec_t               out_rec_q, out_rec_d;
  status_e            out_st_q, out_st_d;
  logic [IDX_W-1:0]   out_pos_q, out_pos_d;
  logic [CNT_W-1:0]   out_total_q, out_total_d;
  logic               out_last_q, out_last_d;

  // memory and comparator hookup
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  rec_t               mem_wdata, mem_rdata;
  key_t               cmp_a;
  cmp_t               cmp_res;

  logic               out_free, idx_last, i_last, full, in_xfer;
  rec_t               zero_rec, in_rec;

  krt_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  krt_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (mem_rdata.key),
    .res_o (cmp_res)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign idx_last = (CNT_W'(idx_q) + CNT_W'(1)) == used_q;
  assign i_last   = (CNT_W'(i_q) + CNT_W'(1)) == used_q;
  assign full     = (used_q == CNT_W'(ENTRIES));
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign zero_rec = '0;

  always_comb begin
    in_rec.key    = key_i;
    in_rec.title  = title_tag_i;
    in_rec.author = author_tag_i;
    in_rec.price  = price_cents_i;
  end

  // comparator operand: the command key, the held record or the pending list entry
  always_comb begin
    case (state_q)
      S_SORT_CMP: cmp_a = hold_q.key;
      S_LIST_CMP: cmp_a = pend_q.key;
      default:    cmp_a = nrec_q.key;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    i_d         = i_q;
    used_d      = used_q;
    cmd_d       = cmd_q;
    nrec_d      = nrec_q;
    hold_d      = hold_q;
    pend_d      = pend_q;
    pend_pos_d  = pend_pos_q;
    pend_v_d    = pend_v_q;
    res_d       = res_q;
    res_pos_d   = res_pos_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rec_d   = out_rec_q;
    out_st_d    = out_st_q;
    out_pos_d   = out_pos_q;
    out_total_d = out_total_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = hold_q;
    mem_raddr   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d     = cmd_e'(cmd_i);
          nrec_d    = in_rec;
          idx_d     = '0;
          i_d       = '0;
          res_d     = zero_rec;
          res_pos_d = '0;
          case (cmd_e'(cmd_i))
            CMD_INSERT: begin
              if (full) begin
                res_st_d = ST_FULL;
                state_d  = S_EMIT;
              end else if (used_q == '0) begin
                state_d = S_INS_WR;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            CMD_LOOKUP, CMD_UPDATE, CMD_REMOVE: begin
              if (used_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_EMIT;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            CMD_LIST: begin
              if (used_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_EMIT;
              end else begin
                state_d = S_SORT_LD;
              end
            end
            default: state_d = S_IDLE;  // unused codes are dropped
          endcase
        end
      end

      S_SRCH_RD: state_d = S_SRCH_CMP;

      S_SRCH_CMP: begin
        if (cmp_res.eq) begin
          res_st_d  = ST_OK;
          res_pos_d = idx_q;
          res_d     = mem_rdata;
          state_d   = S_EMIT;
          case (cmd_q)
            CMD_INSERT: begin
              res_st_d  = ST_DUP;
              res_d     = zero_rec;
              res_pos_d = '0;
            end
            CMD_UPDATE: begin
              mem_we    = 1'b1;
              mem_wdata = nrec_q;
              res_d     = nrec_q;
            end
            CMD_REMOVE: begin
              if (idx_last) begin
                used_d = used_q - CNT_W'(1);
              end else begin
                idx_d   = idx_q + IDX_W'(1);
                state_d = S_SHIFT_RD;
              end
            end
            default: ;
          endcase
        end else if (idx_last) begin
          if (cmd_q == CMD_INSERT) begin
            state_d = S_INS_WR;
          end else begin
            res_st_d = ST_MISSING;
            state_d  = S_EMIT;
          end
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_SRCH_RD;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = used_q[IDX_W-1:0];
        mem_wdata = nrec_q;
        res_d     = nrec_q;
        res_pos_d = used_q[IDX_W-1:0];
        res_st_d  = ST_OK;
        used_d    = used_q + CNT_W'(1);
        state_d   = S_EMIT;
      end

      // close the gap left by a removed record, one slot per pass
      S_SHIFT_RD: state_d = S_SHIFT_WR;

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q - IDX_W'(1);
        mem_wdata = mem_rdata;
        if (idx_last) begin
          used_d  = used_q - CNT_W'(1);
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_SHIFT_RD;
        end
      end

      // exchange sort: slot i is held in a register while idx walks past it
      S_SORT_LD: begin
        mem_raddr = i_q;
        state_d   = S_SORT_HOLD;
      end

      S_SORT_HOLD: begin
        hold_d = mem_rdata;
        if (i_last) begin
          idx_d    = '0;
          pend_v_d = 1'b0;
          state_d  = S_LIST_RD;
        end else begin
          idx_d   = i_q + IDX_W'(1);
          state_d = S_SORT_RD;
        end
      end

      S_SORT_RD: state_d = S_SORT_CMP;

      S_SORT_CMP: begin
        if (cmp_res.gt) begin
          mem_we    = 1'b1;
          mem_wdata = hold_q;
          hold_d    = mem_rdata;
        end
        if (idx_last) begin
          state_d = S_SORT_PUT;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_SORT_RD;
        end
      end

      S_SORT_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = hold_q;
        i_d       = i_q + IDX_W'(1);
        state_d   = S_SORT_LD;
      end

      // list: each new id pushes out the one before it, the last leaves marked
      S_LIST_RD: state_d = S_LIST_CMP;

      S_LIST_CMP: begin
        if (!pend_v_q || !cmp_res.eq) begin
          if (pend_v_q && !out_free) begin
            state_d = S_LIST_CMP;  // hold the read until the output frees
          end else begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_rec_d   = pend_q;
              out_st_d    = ST_OK;
              out_pos_d   = pend_pos_q;
              out_total_d = used_q;
              out_last_d  = 1'b0;
            end
            pend_d     = mem_rdata;
            pend_pos_d = idx_q;
            pend_v_d   = 1'b1;
            if (idx_last) begin
              state_d = S_LIST_END;
            end else begin
              idx_d   = idx_q + IDX_W'(1);
              state_d = S_LIST_RD;
            end
          end
        end else if (idx_last) begin
          state_d = S_LIST_END;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_LIST_RD;
        end
      end

      S_LIST_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rec_d   = pend_q;
          out_st_d    = ST_OK;
          out_pos_d   = pend_pos_q;
          out_total_d = used_q;
          out_last_d  = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rec_d   = res_q;
          out_st_d    = res_st_q;
          out_pos_d   = res_pos_q;
          out_total_d = used_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    i_q         <= i_d;
    cmd_q       <= cmd_d;
    nrec_q      <= nrec_d;
    hold_q      <= hold_d;
    pend_q      <= pend_d;
    pend_pos_q  <= pend_pos_d;
    res_q       <= res_d;
    res_pos_q   <= res_pos_d;
    res_st_q    <= res_st_d;
    out_rec_q   <= out_rec_d;
    out_st_q    <= out_st_d;
    out_pos_q   <= out_pos_d;
    out_total_q <= out_total_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign found_key_o    = out_rec_q.key;
  assign found_title_o  = out_rec_q.title;
  assign found_author_o = out_rec_q.author;
  assign found_price_o  = out_rec_q.price;
  assign position_o     = out_pos_q;
  assign entry_total_o  = out_total_q;
  assign last_o         = out_last_q;

`ifndef SYNTH
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(ENTRIES))
    else $error("entry count beyond table size");

  a_sort_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SORT_LD) |-> (used_q != '0) && (CNT_W'(i_q) < used_q))
    else $error("sort pass on an empty table");

  a_shift_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_WR) |-> (idx_q != '0) && (CNT_W'(idx_q) < used_q))
    else $error("shift outside the filled slots");

  a_search_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_CMP) |-> CNT_W'(idx_q) < used_q)
    else $error("search beyond the filled slots");
`endif

endmodule
`default_nettype wire
